// ----- rtl/core/jbps_pkg.sv -----
`timescale 1ns / 1ps

package jbps_pkg;

   // Defaults for the top-level parameters
   localparam int unsigned SLOTS_MAX_DEF   = 128;
   localparam int unsigned TABLE_DEPTH_DEF = 256;
   localparam int unsigned WINDOW_MAX_DEF  = 32;
   localparam int unsigned TIME_BITS_DEF   = 40;

   // Fixed field widths
   localparam int unsigned SEQ_W      = 16;
   localparam int unsigned TOL_W      = 18;
   localparam int unsigned SLOTS_W    = 8;
   localparam int unsigned LW_W       = 6;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned SLOT_W     = 7;
   localparam int unsigned SKIP_W     = 8;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 18;

   // Index and modulus arithmetic: holds a modulus of up to 256 and the 9-bit playout index
   localparam int unsigned NUM_W  = 9;
   localparam int unsigned STEP_W = $clog2(SEQ_W + 1);
   localparam int unsigned PAD_W  = SEQ_W - NUM_W;

   // Stream stall threshold in microseconds
   localparam int unsigned STALL_US = 30000;

   // Reset values
   localparam logic [NUM_W-1:0]   PLAYOUT_RESET     = '1;
   localparam logic [SLOTS_W-1:0] NUM_SLOTS_RESET   = 8'd128;
   localparam logic [LW_W-1:0]    LOST_WINDOW_RESET = 6'd32;

   // Operation codes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_PULL = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_SLOTS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOST_WINDOW = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SKIP     = 2'd1,
      STATUS_UNDERRUN = 2'd2,
      STATUS_SILENCE  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH_MOD,
      ST_PULL_NEWEST,
      ST_PULL_PLAY,
      ST_PULL_BACK,
      ST_SCAN,
      ST_FINISH,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic              start;
      logic [SEQ_W-1:0]  dividend;
      logic [STEP_W-1:0] steps;
      logic [NUM_W-1:0]  divisor;
   } jbps_mod_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] remainder;
   } jbps_mod_rsp_type;

endpackage

// ----- rtl/core/jbps_if.sv -----
`timescale 1ns / 1ps

interface jbps_req_if import jbps_pkg::*; #(
   parameter int unsigned TIME_BITS = TIME_BITS_DEF
);
   logic                 valid;
   logic                 ready;
   logic                 operation;
   logic [SEQ_W-1:0]     seq_num;
   logic [TIME_BITS-1:0] now_us;

   modport source (output valid, operation, seq_num, now_us, input ready);
   modport sink (input valid, operation, seq_num, now_us, output ready);
endinterface

interface jbps_rsp_if import jbps_pkg::*;;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot_index;
   logic [SKIP_W-1:0]   skip_count;

   modport source (output valid, status, slot_index, skip_count, input ready);
   modport sink (input valid, status, slot_index, skip_count, output ready);
endinterface

// ----- rtl/core/jitter_buffer_playout_scheduler.sv -----
`timescale 1ns / 1ps
// Push: 16 remainder steps (one per cycle), then the deadline table write.
// Pull: three 9-step remainders in the shared remainder unit, then one deadline table read
// per cycle over up to lost_window + 1 entries, ending at the first live entry taken.
// One request is in work at a time; the output register lets the next request in while a
// result waits. Synchronous active-high reset: table valid bits cleared, control registers to defaults.
module jitter_buffer_playout_scheduler import jbps_pkg::*; #(
   parameter int unsigned SLOTS_MAX   = SLOTS_MAX_DEF,
   parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int unsigned WINDOW_MAX  = WINDOW_MAX_DEF,
   parameter int unsigned TIME_BITS   = TIME_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   jbps_req_if.sink              req_bus,
   jbps_rsp_if.source            rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned DL_W   = TIME_BITS + 1;
   localparam int unsigned SUM_W  = DL_W + 1;
   localparam int unsigned SCAN_W = LW_W + 1;

   // Configuration
   logic [TOL_W-1:0]   tol_ff;
   logic [SLOTS_W-1:0] num_slots_ff;
   logic [LW_W-1:0]    lost_window_ff;
   logic [SLOTS_W-1:0] eff_slots;
   logic [NUM_W-1:0]   two_slots;
   logic [NUM_W-1:0]   modulus;
   logic [LW_W-1:0]    lw_eff;

   // Control and state
   state_type          state_ff;
   state_type          state_in;
   logic               req_take;
   logic [TIME_BITS-1:0] now_ff;
   logic [IDX_W-1:0]   newest_idx_ff;
   logic               newest_valid_ff;
   logic [NUM_W-1:0]   newest_red_ff;
   logic [NUM_W-1:0]   pi_ff;
   logic [DL_W-1:0]    cur_dl_ff;
   logic [NUM_W-1:0]   skip_ff;
   logic [NUM_W-1:0]   scan_addr_ff;
   logic [SCAN_W-1:0]  scan_cnt_ff;

   // Deadline table
   logic [DL_W-1:0]        dl_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic                   wr_en;
   logic [NUM_W-1:0]       wr_addr;
   logic [DL_W-1:0]        wr_data;
   logic                   rd_en;
   logic                   rd_scan;
   logic [NUM_W-1:0]       rd_addr;
   logic [DL_W-1:0]        rd_data_ff;
   logic                   rd_valid_ff;
   logic [NUM_W-1:0]       rd_addr_ff;
   logic                   rd_scan_ff;
   logic                   cur_cap_ff;
   logic                   cur_cap_in;

   // Remainder unit
   jbps_mod_req_type   mod_req;
   jbps_mod_rsp_type   mod_rsp;

   // Scan datapath
   logic [DL_W-1:0]    rd_dl;
   logic               take;
   logic               live;
   logic               hit_take;
   logic               hit_live;
   logic [NUM_W:0]     skip_sum;
   logic [NUM_W:0]     skip_sub;
   logic [NUM_W-1:0]   skip_new;
   logic [NUM_W-1:0]   slot_full;
   logic [NUM_W:0]     start_diff;
   logic [NUM_W:0]     start_fix;
   logic [NUM_W-1:0]   start_addr;
   logic [NUM_W-1:0]   scan_next;
   logic [SUM_W-1:0]   stall_sum;
   logic               stalled;
   logic               scan_done;

   // Result and output registers
   logic               res_load;
   status_type         res_status_in;
   logic [SLOT_W-1:0]  res_slot_in;
   logic [SKIP_W-1:0]  res_skip_in;
   status_type         res_status_ff;
   logic [SLOT_W-1:0]  res_slot_ff;
   logic [SKIP_W-1:0]  res_skip_ff;
   logic               out_load;
   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;
   logic [SKIP_W-1:0]  rsp_skip_ff;

   jbps_mod u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   // Clamp configuration to the supported ranges
   always_comb begin
      if (num_slots_ff == '0) begin
         eff_slots = SLOTS_W'(1);
      end else if (num_slots_ff > SLOTS_W'(SLOTS_MAX)) begin
         eff_slots = SLOTS_W'(SLOTS_MAX);
      end else begin
         eff_slots = num_slots_ff;
      end
      two_slots = {eff_slots, 1'b0};
      if (two_slots > NUM_W'(TABLE_DEPTH)) begin
         modulus = NUM_W'(TABLE_DEPTH);
      end else begin
         modulus = two_slots;
      end
      if ({1'b0, lost_window_ff} > (LW_W + 1)'(WINDOW_MAX)) begin
         lw_eff = LW_W'(WINDOW_MAX);
      end else begin
         lw_eff = lost_window_ff;
      end
   end

   assign req_take = req_bus.valid && req_bus.ready;

   // Scan compare, skip distance and wrap arithmetic
   always_comb begin
      rd_dl      = rd_valid_ff ? rd_data_ff : '0;
      take       = (rd_dl >= cur_dl_ff);
      live       = (rd_dl > DL_W'(now_ff));
      hit_take   = (state_ff == ST_SCAN) && rd_scan_ff && take;
      hit_live   = hit_take && live;
      skip_sum   = {1'b0, rd_addr_ff} + {1'b0, modulus} - {1'b0, pi_ff};
      skip_sub   = skip_sum - {1'b0, modulus};
      if (skip_sum >= {1'b0, modulus}) begin
         skip_new = skip_sub[NUM_W-1:0];
      end else begin
         skip_new = skip_sum[NUM_W-1:0];
      end
      if (rd_addr_ff >= NUM_W'(eff_slots)) begin
         slot_full = rd_addr_ff - NUM_W'(eff_slots);
      end else begin
         slot_full = rd_addr_ff;
      end
      start_diff = {1'b0, newest_red_ff} - {1'b0, mod_rsp.remainder};
      start_fix  = start_diff + {1'b0, modulus};
      if (start_diff[NUM_W]) begin
         start_addr = start_fix[NUM_W-1:0];
      end else begin
         start_addr = start_diff[NUM_W-1:0];
      end
      if (scan_addr_ff + NUM_W'(1) == modulus) begin
         scan_next = '0;
      end else begin
         scan_next = scan_addr_ff + NUM_W'(1);
      end
      stall_sum = SUM_W'(cur_dl_ff) + SUM_W'(STALL_US);
      stalled   = (pi_ff == newest_red_ff) && (stall_sum < SUM_W'(now_ff));
      scan_done = (scan_cnt_ff == '0) && !rd_scan_ff;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_bus.operation == OP_PUSH) begin
                  state_in = ST_PUSH_MOD;
               end else if (newest_valid_ff) begin
                  state_in = ST_PULL_NEWEST;
               end else begin
                  state_in = ST_RESULT;
               end
            end
         end
         ST_PUSH_MOD: begin
            if (mod_rsp.done) begin
               state_in = ST_IDLE;
            end
         end
         ST_PULL_NEWEST: begin
            if (mod_rsp.done) begin
               state_in = ST_PULL_PLAY;
            end
         end
         ST_PULL_PLAY: begin
            if (mod_rsp.done) begin
               state_in = ST_PULL_BACK;
            end
         end
         ST_PULL_BACK: begin
            if (mod_rsp.done) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            priority if (hit_live) begin
               state_in = ST_RESULT;
            end else if (scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State outputs: remainder requests, table accesses, result load
   always_comb begin
      mod_req          = '0;
      mod_req.divisor  = modulus;
      wr_en            = 1'b0;
      wr_addr          = mod_rsp.remainder;
      wr_data          = DL_W'(now_ff) + DL_W'(tol_ff);
      rd_en            = 1'b0;
      rd_scan          = 1'b0;
      rd_addr          = scan_addr_ff;
      cur_cap_in       = 1'b0;
      res_load         = 1'b0;
      res_status_in    = STATUS_SILENCE;
      res_slot_in      = '0;
      res_skip_in      = '0;
      out_load         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_bus.operation == OP_PUSH) begin
                  mod_req.start    = 1'b1;
                  mod_req.dividend = req_bus.seq_num;
                  mod_req.steps    = STEP_W'(SEQ_W);
               end else if (newest_valid_ff) begin
                  mod_req.start    = 1'b1;
                  mod_req.dividend = {NUM_W'(newest_idx_ff), {PAD_W{1'b0}}};
                  mod_req.steps    = STEP_W'(NUM_W);
               end else begin
                  res_load = 1'b1;
               end
            end
         end
         ST_PUSH_MOD: begin
            wr_en = mod_rsp.done;
         end
         ST_PULL_NEWEST: begin
            if (mod_rsp.done) begin
               mod_req.start    = 1'b1;
               mod_req.dividend = {pi_ff + NUM_W'(1), {PAD_W{1'b0}}};
               mod_req.steps    = STEP_W'(NUM_W);
            end
         end
         ST_PULL_PLAY: begin
            if (mod_rsp.done) begin
               mod_req.start    = 1'b1;
               mod_req.dividend = {NUM_W'(lw_eff), {PAD_W{1'b0}}};
               mod_req.steps    = STEP_W'(NUM_W);
               rd_en            = 1'b1;
               rd_addr          = mod_rsp.remainder;
               cur_cap_in       = 1'b1;
            end
         end
         ST_PULL_BACK: begin
         end
         ST_SCAN: begin
            rd_en   = (scan_cnt_ff != '0);
            rd_scan = rd_en;
            if (hit_live) begin
               res_load      = 1'b1;
               res_status_in = (skip_new != '0) ? STATUS_SKIP : STATUS_OK;
               res_slot_in   = slot_full[SLOT_W-1:0];
               res_skip_in   = skip_new[SKIP_W-1:0];
            end
         end
         ST_FINISH: begin
            res_load      = 1'b1;
            res_status_in = stalled ? STATUS_SILENCE : STATUS_UNDERRUN;
            res_skip_in   = skip_ff[SKIP_W-1:0];
         end
         ST_RESULT: begin
            out_load = !rsp_valid_ff || rsp_bus.ready;
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         tol_ff          <= '0;
         num_slots_ff    <= NUM_SLOTS_RESET;
         lost_window_ff  <= LOST_WINDOW_RESET;
         newest_idx_ff   <= '0;
         newest_valid_ff <= 1'b0;
         pi_ff           <= PLAYOUT_RESET;
         valid_ff        <= '0;
         rd_scan_ff      <= 1'b0;
         cur_cap_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_scan_ff <= rd_scan;
         cur_cap_ff <= cur_cap_in;

         // Take register writes
         if (csr_we) begin
            unique case (csr_index)
               CSR_TOLERANCE:   tol_ff         <= csr_wdata[TOL_W-1:0];
               CSR_NUM_SLOTS:   num_slots_ff   <= csr_wdata[SLOTS_W-1:0];
               CSR_LOST_WINDOW: lost_window_ff <= csr_wdata[LW_W-1:0];
               default: begin
               end
            endcase
         end

         // Mark the pushed entry as newest
         if (wr_en) begin
            newest_idx_ff             <= wr_addr[IDX_W-1:0];
            newest_valid_ff           <= 1'b1;
            valid_ff[wr_addr[IDX_W-1:0]] <= 1'b1;
         end

         // Advance the playout index, then follow the scan
         if (state_ff == ST_PULL_PLAY && mod_rsp.done) begin
            pi_ff <= mod_rsp.remainder;
         end else if (hit_take) begin
            pi_ff <= rd_addr_ff;
         end

         // Hold the result until the sink takes it
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Deadline table: one write or one read per cycle, never both, so no forwarding
   always_ff @(posedge clock) begin
      if (wr_en) begin
         dl_mem[wr_addr[IDX_W-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= dl_mem[rd_addr[IDX_W-1:0]];
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_valid_ff <= valid_ff[rd_addr[IDX_W-1:0]];
      rd_addr_ff  <= rd_addr;
      if (req_take) begin
         now_ff <= req_bus.now_us;
      end
      if (state_ff == ST_PULL_NEWEST && mod_rsp.done) begin
         newest_red_ff <= mod_rsp.remainder;
      end
      // Load the deadline of the advanced playout entry, or of the entry that the scan takes
      if (cur_cap_ff) begin
         cur_dl_ff <= rd_dl;
      end else if (hit_take) begin
         cur_dl_ff <= rd_dl;
      end
      if (state_ff == ST_PULL_BACK && mod_rsp.done) begin
         scan_addr_ff <= start_addr;
         scan_cnt_ff  <= SCAN_W'(lw_eff) + SCAN_W'(1);
         skip_ff      <= '0;
      end else begin
         if (rd_scan) begin
            scan_addr_ff <= scan_next;
            scan_cnt_ff  <= scan_cnt_ff - SCAN_W'(1);
         end
         if (hit_take) begin
            skip_ff <= skip_new;
         end
      end
      if (res_load) begin
         res_status_ff <= res_status_in;
         res_slot_ff   <= res_slot_in;
         res_skip_ff   <= res_skip_in;
      end
      if (out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_skip_ff   <= res_skip_ff;
      end
   end

   assign req_bus.ready      = (state_ff == ST_IDLE);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.slot_index = rsp_slot_ff;
   assign rsp_bus.skip_count = rsp_skip_ff;

endmodule

// ----- rtl/core/jbps_mod.sv -----
`timescale 1ns / 1ps

// Restoring remainder unit: one dividend bit per cycle, MSB first
module jbps_mod import jbps_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  jbps_mod_req_type mod_req,
   output jbps_mod_rsp_type mod_rsp
);

   logic              busy_ff;
   logic              done_ff;
   logic              done_in;
   logic [STEP_W-1:0] cnt_ff;
   logic [SEQ_W-1:0]  dvd_ff;
   logic [NUM_W-1:0]  div_ff;
   logic [NUM_W-1:0]  rem_ff;
   logic [NUM_W-1:0]  rem_in;
   logic [NUM_W:0]    trial;
   logic [NUM_W:0]    diff;

   // Shift in the next dividend bit and subtract the divisor where it fits
   always_comb begin
      trial = {rem_ff, dvd_ff[SEQ_W-1]};
      diff  = trial - {1'b0, div_ff};
      if (trial >= {1'b0, div_ff}) begin
         rem_in = diff[NUM_W-1:0];
      end else begin
         rem_in = trial[NUM_W-1:0];
      end
      done_in = busy_ff && (cnt_ff == STEP_W'(1));
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
         if (mod_req.start) begin
            busy_ff <= 1'b1;
         end else if (done_in) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (mod_req.start) begin
         cnt_ff <= mod_req.steps;
         dvd_ff <= mod_req.dividend;
         div_ff <= mod_req.divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - STEP_W'(1);
         dvd_ff <= {dvd_ff[SEQ_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign mod_rsp.done      = done_ff;
   assign mod_rsp.remainder = rem_ff;

endmodule
